// ----- design/matrix3_inverse_and_solve_defines.svh -----
// assertion macros used by the matrix inverse and solve back end
`ifndef MATRIX3_INVERSE_AND_SOLVE_DEFINES_SVH
`define MATRIX3_INVERSE_AND_SOLVE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define M3I_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m3i check failed");

// next-cycle implication
`define M3I_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("m3i check failed");

`endif

// ----- design/m3i_pkg.sv -----
// shared types and constants for the 3x3 inverse and solve block
package m3i_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;
	localparam int PROD_W = 64;
	localparam int COF_W = 65;
	localparam int DET_W = 97;
	localparam int MAG_W = 96;
	localparam int NUM_W = 128;
	localparam int THR_W = 31;
	localparam int IDX_W = 4;
	localparam int QUO_W = 32;
	localparam int N_COF = 9;
	localparam int N_SOL = 3;
	localparam int IN_W = WORD_W * (N_COF + N_SOL);
	localparam int OUT_W = 72;
	localparam int USER_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] IDX_FIRST_SOL = 4'd9;
	localparam logic [IDX_W-1:0] IDX_LAST = 4'd11;
	localparam logic [WORD_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;

	// one classified matrix waiting for the divider
	typedef struct packed {
		cof_t [N_COF-1:0] cof;
		det_t [N_SOL-1:0] cramer;
		logic [MAG_W-1:0] det_mag;
		logic det_neg;
		logic singular;
		logic [WORD_W-1:0] det_out;
	} job_t;
endpackage

// ----- design/m3i_front.sv -----
// front end: cofactors, determinant, cramer numerators and singular check
module m3i_front #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [m3i_pkg::IN_W-1:0] in_data,
	input  logic [m3i_pkg::THR_W-1:0] threshold,
	output logic out_valid,
	input  logic out_ready,
	output m3i_pkg::job_t out_job
);
	import m3i_pkg::*;

	localparam int N_MUL = N_SOL + N_COF;
	// cofactor k = a[p1]*a[p2] - a[q1]*a[q2]
	localparam int COF_SRC [N_COF][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	logic signed [WORD_W-1:0] a_in [N_COF];
	logic signed [WORD_W-1:0] b_in [N_SOL];
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PROD_W-1:0] pa_s1 [N_COF];
	logic signed [PROD_W-1:0] pb_s1 [N_COF];
	logic signed [WORD_W-1:0] row_s1 [N_SOL];
	logic signed [WORD_W-1:0] b_s1 [N_SOL];
	logic signed [WORD_W-1:0] row_s2 [N_SOL];
	logic signed [WORD_W-1:0] b_s2 [N_SOL];
	logic signed [COF_W-1:0] cof_s2 [N_COF];
	logic signed [COF_W-1:0] cof_s3 [N_COF];
	logic signed [COF_W-1:0] cof_s4 [N_COF];
	logic signed [COF_W-1:0] cof_s5 [N_COF];
	logic signed [COF_W-1:0] lo_s3 [N_MUL];
	logic signed [COF_W-1:0] hi_s3 [N_MUL];
	logic signed [DET_W-1:0] prod_s4 [N_MUL];
	logic signed [DET_W-1:0] det_s5;
	logic signed [DET_W-1:0] cr_s5 [N_SOL];
	logic [DET_W-1:0] det_abs;
	logic signed [DET_W-1:0] det_shr;
	logic [NUM_W-1:0] thr_lim;

	assign en = ~v_s5 | out_ready;
	assign in_ready = en;
	assign out_valid = v_s5;

	always_comb begin
		for (int i = 0; i < N_COF; i++) a_in[i] = in_data[WORD_W*i +: WORD_W];
		for (int i = 0; i < N_SOL; i++) b_in[i] = in_data[WORD_W*(N_COF+i) +: WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_COF; k++) begin
				pa_s1[k] <= a_in[COF_SRC[k][0]] * a_in[COF_SRC[k][1]];
				pb_s1[k] <= a_in[COF_SRC[k][2]] * a_in[COF_SRC[k][3]];
				cof_s2[k] <= $signed({pa_s1[k][PROD_W-1], pa_s1[k]})
					- $signed({pb_s1[k][PROD_W-1], pb_s1[k]});
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
			for (int i = 0; i < N_SOL; i++) begin
				row_s1[i] <= a_in[i];
				b_s1[i] <= b_in[i];
				row_s2[i] <= row_s1[i];
				b_s2[i] <= b_s1[i];
			end
			// cofactor times a word, split into low and high partial products
			for (int m = 0; m < N_MUL; m++) begin
				if (m < N_SOL) begin
					lo_s3[m] <= $signed({1'b0, cof_s2[m*N_SOL][WORD_W-1:0]}) * row_s2[m];
					hi_s3[m] <= $signed(cof_s2[m*N_SOL][COF_W-1:WORD_W]) * row_s2[m];
				end else begin
					lo_s3[m] <= $signed({1'b0, cof_s2[m-N_SOL][WORD_W-1:0]})
						* b_s2[(m-N_SOL)%N_SOL];
					hi_s3[m] <= $signed(cof_s2[m-N_SOL][COF_W-1:WORD_W])
						* b_s2[(m-N_SOL)%N_SOL];
				end
				prod_s4[m] <= $signed({hi_s3[m], {WORD_W{1'b0}}})
					+ $signed({{(DET_W-COF_W){lo_s3[m][COF_W-1]}}, lo_s3[m]});
			end
			det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
			for (int c = 0; c < N_SOL; c++) begin
				cr_s5[c] <= prod_s4[N_SOL+N_SOL*c] + prod_s4[N_SOL+N_SOL*c+1]
					+ prod_s4[N_SOL+N_SOL*c+2];
			end
		end
	end

	assign thr_lim = NUM_W'(threshold) << (2*FRAC_BITS);

	always_comb begin
		for (int k = 0; k < N_COF; k++) out_job.cof[k] = cof_s5[k];
		for (int c = 0; c < N_SOL; c++) out_job.cramer[c] = cr_s5[c];
		out_job.det_neg = det_s5[DET_W-1];
		det_abs = det_s5[DET_W-1] ? -det_s5 : det_s5;
		out_job.det_mag = det_abs[MAG_W-1:0];
		out_job.singular = (det_s5 == '0) || (NUM_W'(det_abs[MAG_W-1:0]) < thr_lim);
		det_shr = det_s5 >>> (2*FRAC_BITS);
		if ((&det_shr[DET_W-1:WORD_W-1]) || !(|det_shr[DET_W-1:WORD_W-1])) begin
			out_job.det_out = det_shr[WORD_W-1:0];
		end else begin
			out_job.det_out = det_s5[DET_W-1] ? SAT_NEG : SAT_POS;
		end
	end
endmodule

// ----- design/m3i_queue.sv -----
// short job queue between the front end and the divider
module m3i_queue #(
	parameter int DEPTH = m3i_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  m3i_pkg::job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output m3i_pkg::job_t pop_data
);
	import m3i_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = slot_q[rd_q];
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end
endmodule

// ----- design/m3i_back.sv -----
// back end: result sequencer, pipelined divider and output register
`include "matrix3_inverse_and_solve_defines.svh"
module m3i_back #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  m3i_pkg::job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic [m3i_pkg::OUT_W-1:0] out_data,
	output logic [m3i_pkg::USER_W-1:0] out_user,
	output logic out_last
);
	import m3i_pkg::*;

	// one overflow check plus one step per quotient bit
	localparam int N_ST = QUO_W + 1;
	localparam int PAD_W = OUT_W - IDX_W - 2*WORD_W;

	logic [IDX_W-1:0] k_q;
	logic en, issue;
	logic signed [DET_W-1:0] num_sel;
	logic [DET_W-1:0] num_abs;
	logic [NUM_W-1:0] num_sh;

	logic v_s [N_ST+1];
	logic [NUM_W-1:0] rem_s [N_ST+1];
	logic [MAG_W-1:0] den_s [N_ST+1];
	logic [QUO_W-1:0] quo_s [N_ST+1];
	logic ovf_s [N_ST+1];
	logic neg_s [N_ST+1];
	logic sing_s [N_ST+1];
	logic last_s [N_ST+1];
	logic [IDX_W-1:0] idx_s [N_ST+1];
	logic [WORD_W-1:0] dout_s [N_ST+1];

	logic [NUM_W-1:0] dsh [N_ST];
	logic [NUM_W-1:0] rem_n [N_ST];
	logic [QUO_W-1:0] quo_n [N_ST];
	logic ovf_n [N_ST];

	logic [QUO_W-1:0] quo_f;
	logic [WORD_W-1:0] val_f;
	logic ovf_f;

	logic out_valid_q, sing_q, ovf_q, last_q;
	logic [IDX_W-1:0] idx_q;
	logic [WORD_W-1:0] val_q, dout_q;

	assign en = ~out_valid_q | out_ready;
	assign issue = job_valid & en;
	assign job_ready = issue & (job.singular | (k_q == IDX_LAST));

	always_comb begin
		num_sel = '0;
		for (int i = 0; i < N_COF; i++) begin
			if (k_q == IDX_W'(i)) begin
				num_sel = {{(DET_W-COF_W){job.cof[i][COF_W-1]}}, job.cof[i]};
			end
		end
		for (int i = 0; i < N_SOL; i++) begin
			if (k_q == IDX_FIRST_SOL + IDX_W'(i)) num_sel = job.cramer[i];
		end
		num_abs = num_sel[DET_W-1] ? -num_sel : num_sel;
		if (k_q < IDX_FIRST_SOL) num_sh = NUM_W'(num_abs) << (2*FRAC_BITS);
		else num_sh = NUM_W'(num_abs) << FRAC_BITS;
	end

	// restoring division; the first step only flags a quotient of 2^32 or more
	always_comb begin
		for (int j = 0; j < N_ST; j++) begin
			dsh[j] = NUM_W'(den_s[j]) << (QUO_W - j);
			rem_n[j] = rem_s[j];
			quo_n[j] = quo_s[j];
			ovf_n[j] = ovf_s[j];
			if (j == 0) begin
				ovf_n[j] = rem_s[j] >= dsh[j];
			end else if (rem_s[j] >= dsh[j]) begin
				rem_n[j] = rem_s[j] - dsh[j];
				quo_n[j] = quo_s[j] | (QUO_W'(1) << (QUO_W - j));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= N_ST; j++) v_s[j] <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= issue;
			for (int j = 0; j < N_ST; j++) v_s[j+1] <= v_s[j];
			out_valid_q <= v_s[N_ST];
			if (issue) k_q <= job_ready ? '0 : k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_sh;
			den_s[0] <= job.det_mag;
			quo_s[0] <= '0;
			ovf_s[0] <= 1'b0;
			neg_s[0] <= num_sel[DET_W-1] ^ job.det_neg;
			sing_s[0] <= job.singular;
			last_s[0] <= job.singular | (k_q == IDX_LAST);
			idx_s[0] <= job.singular ? '0 : k_q;
			dout_s[0] <= job.det_out;
			for (int j = 0; j < N_ST; j++) begin
				rem_s[j+1] <= rem_n[j];
				den_s[j+1] <= den_s[j];
				quo_s[j+1] <= quo_n[j];
				ovf_s[j+1] <= ovf_n[j];
				neg_s[j+1] <= neg_s[j];
				sing_s[j+1] <= sing_s[j];
				last_s[j+1] <= last_s[j];
				idx_s[j+1] <= idx_s[j];
				dout_s[j+1] <= dout_s[j];
			end
			idx_q <= idx_s[N_ST];
			val_q <= val_f;
			dout_q <= dout_s[N_ST];
			sing_q <= sing_s[N_ST];
			ovf_q <= ovf_f;
			last_q <= last_s[N_ST];
		end
	end

	// sign, saturation and singular zeroing of the finished quotient
	always_comb begin
		quo_f = quo_s[N_ST];
		val_f = neg_s[N_ST] ? -quo_f : quo_f;
		ovf_f = 1'b0;
		if (sing_s[N_ST]) begin
			val_f = '0;
		end else if (ovf_s[N_ST]
				|| (!neg_s[N_ST] && quo_f[QUO_W-1])
				|| (neg_s[N_ST] && quo_f > SAT_NEG)) begin
			val_f = neg_s[N_ST] ? SAT_NEG : SAT_POS;
			ovf_f = 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = {{PAD_W{1'b0}}, dout_q, val_q, idx_q};
	assign out_user = {ovf_q, sing_q};
	assign out_last = last_q;

	`M3I_ASSERT_NOW(a_last_on_final, out_valid_q && last_q, sing_q || (idx_q == IDX_LAST))
	`M3I_ASSERT_NOW(a_singular_shape, out_valid_q && sing_q, last_q && (val_q == '0) && !ovf_q)
	`M3I_ASSERT_NOW(a_seq_range, 1'b1, k_q <= IDX_LAST)
	`M3I_ASSERT_NEXT(a_pop_restarts, job_ready, k_q == '0)
endmodule

// ----- design/matrix3_inverse_and_solve.sv -----
// top level of the 3x3 matrix inverse and linear solve block
// usage:
//   s_axis carries one matrix and right-hand side per transaction (Q16.16 by default).
//   m_axis returns one result per transaction: twelve for a regular matrix (inverse
//   entries 0-8 row-major, then solution entries 9-11), one for a singular matrix,
//   the final one of each input marked by m_axis_tlast.
//   cfg writes the singular threshold; cfg_ready is always high.
//   the divider takes one quotient per cycle while the output is not stalled; the
//   front end takes one matrix a cycle until the two-entry job queue fills.
//   the divider is a 33 stage restoring pipeline: an overflow check, then one
//   quotient bit per stage.
//   reset clears all pipelines and the queue and sets the threshold to 1.
//   when m_axis_tready is low with a result pending, the output holds and the divider
//   freezes; the queue and front end take inputs until full, then s_axis_tready drops.
module matrix3_inverse_and_solve #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a00 a01 a02 a10 a11 a12 a20 a21 a22 b0 b1 b2, 32 bits each
	input  logic [m3i_pkg::IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// entry_index[3:0] value[35:4] determinant[67:36], zero pad
	output logic [m3i_pkg::OUT_W-1:0] m_axis_tdata,
	// singular[0] overflow[1]
	output logic [m3i_pkg::USER_W-1:0] m_axis_tuser,
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [m3i_pkg::THR_W-1:0] cfg_data
);
	import m3i_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic f_valid, f_ready, j_valid, j_ready;
	job_t f_job, j_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_W'(1);
		else if (cfg_valid) thr_q <= cfg_data;
	end

	m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.threshold(thr_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
	);

	m3i_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
		.pop_valid(j_valid), .pop_ready(j_ready), .pop_data(j_job)
	);

	m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(j_valid), .job_ready(j_ready), .job(j_job),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.out_user(m_axis_tuser), .out_last(m_axis_tlast)
	);
endmodule
